// ===== hdl/lcir_pkg.sv =====
`timescale 1ns / 1ps

package lcir_pkg;

    localparam int SEQ_W = 32;
    localparam int OPC_W = 15;
    localparam int PC_W = 64;
    localparam int LAT_W = 8;

    localparam logic ACT_ACCEPT = 1'b0;
    localparam logic ACT_TICK = 1'b1;
    localparam logic signed [15:0] BUBBLE_OPCODE = -16'sd1;

    typedef struct packed {
        logic             action;
        logic [SEQ_W-1:0] seq_num;
        logic [OPC_W-1:0] opcode;
        logic [PC_W-1:0]  pc;
        logic [LAT_W-1:0] exec_latency;
    } in_item_t;

    typedef struct packed {
        logic               is_bubble;
        logic [SEQ_W-1:0]   retired_seq;
        logic signed [15:0] retired_opcode;
        logic [PC_W-1:0]    retired_pc;
        logic               overflow;
        logic               last_slot;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic do_accept;
        logic do_countdown;
        logic do_search;
        logic do_retire;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
    } dp_status_t;

endpackage

// ===== hdl/lcir_ctrl.sv =====
`timescale 1ns / 1ps

module lcir_ctrl #(
    parameter int RETIRE_WIDTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic                in_action,
    input  logic                out_fire,
    output logic                busy,
    output logic                out_valid,
    output logic                last_slot,
    output lcir_pkg::dp_cmd_t   cmd
);
    import lcir_pkg::*;

    localparam int SW = (RETIRE_WIDTH > 1) ? $clog2(RETIRE_WIDTH) : 1;

    state_t        state_reg, state_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic          last;

    assign last = (slot_reg == SW'(RETIRE_WIDTH - 1));

    always_comb
    begin
        state_next = state_reg;
        slot_next = slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_action == ACT_TICK)
                begin
                    state_next = ST_SEARCH;
                    slot_next = '0;
                end
            end
            ST_SEARCH:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    if (last)
                        state_next = ST_IDLE;
                    else
                    begin
                        state_next = ST_SEARCH;
                        slot_next = slot_reg + SW'(1);
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                cmd.do_accept = in_fire && in_action == ACT_ACCEPT;
                cmd.do_countdown = in_fire && in_action == ACT_TICK;
            end
            ST_SEARCH:
                cmd.do_search = 1'b1;
            ST_EMIT:
            begin
                out_valid = 1'b1;
                cmd.do_retire = out_fire;
            end
            default:
                busy = 1'b1;
        endcase
    end

    assign last_slot = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg <= slot_next;
        end
    end

    a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == ST_EMIT) else $error("output valid outside emit");
    a_search_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEARCH |=> state_reg == ST_EMIT) else $error("search not followed by emit");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.do_accept) else $error("accept while busy");

endmodule

// ===== hdl/lcir_dp.sv =====
`timescale 1ns / 1ps

module lcir_dp #(
    parameter int WINDOW_DEPTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcir_pkg::in_item_t    in_item,
    input  lcir_pkg::dp_cmd_t     cmd,
    input  logic                  last_slot,
    output lcir_pkg::dp_status_t  status,
    output lcir_pkg::out_item_t   out_item
);
    import lcir_pkg::*;

    localparam int IW = $clog2(WINDOW_DEPTH);

    logic [WINDOW_DEPTH-1:0] valid_reg;
    logic [WINDOW_DEPTH-1:0] fin_reg;
    logic [SEQ_W-1:0]        seq_reg [WINDOW_DEPTH];
    logic [OPC_W-1:0]        opc_reg [WINDOW_DEPTH];
    logic [PC_W-1:0]         pc_reg [WINDOW_DEPTH];
    logic [LAT_W-1:0]        rem_reg [WINDOW_DEPTH];
    logic [SEQ_W-1:0]        expected_reg;
    logic                    overflow_reg;
    logic                    hit_reg;
    logic [IW-1:0]           hit_idx_reg;

    logic [WINDOW_DEPTH-1:0] match;
    logic [IW-1:0]           match_idx;
    logic                    match_any;
    logic [IW-1:0]           free_idx;
    logic                    free_any;

    always_comb
    begin
        match_idx = '0;
        match_any = 1'b0;
        free_idx = '0;
        free_any = 1'b0;
        for (int k = WINDOW_DEPTH - 1; k >= 0; k--)
        begin
            match[k] = valid_reg[k] && fin_reg[k] && seq_reg[k] == expected_reg;
            if (match[k])
            begin
                match_any = 1'b1;
                match_idx = IW'(k);
            end
            if (!valid_reg[k])
            begin
                free_any = 1'b1;
                free_idx = IW'(k);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < WINDOW_DEPTH; k++)
        begin
            if (cmd.do_countdown && valid_reg[k] && !fin_reg[k])
                rem_reg[k] <= (rem_reg[k] <= LAT_W'(1)) ? '0 : rem_reg[k] - LAT_W'(1);
        end
        if (cmd.do_accept && free_any)
        begin
            seq_reg[free_idx] <= in_item.seq_num;
            opc_reg[free_idx] <= in_item.opcode;
            pc_reg[free_idx] <= in_item.pc;
            rem_reg[free_idx] <= in_item.exec_latency;
        end
        if (cmd.do_search)
            hit_idx_reg <= match_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fin_reg <= '0;
            expected_reg <= SEQ_W'(1);
            overflow_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_accept)
            begin
                if (free_any)
                begin
                    valid_reg[free_idx] <= 1'b1;
                    fin_reg[free_idx] <= 1'b0;
                end
                else
                    overflow_reg <= 1'b1;
            end
            if (cmd.do_countdown)
            begin
                for (int k = 0; k < WINDOW_DEPTH; k++)
                begin
                    if (valid_reg[k] && !fin_reg[k] && rem_reg[k] <= LAT_W'(1))
                        fin_reg[k] <= 1'b1;
                end
            end
            if (cmd.do_search)
                hit_reg <= match_any;
            if (cmd.do_retire && hit_reg)
            begin
                valid_reg[hit_idx_reg] <= 1'b0;
                fin_reg[hit_idx_reg] <= 1'b0;
                expected_reg <= expected_reg + SEQ_W'(1);
            end
        end
    end

    always_comb
    begin
        out_item.is_bubble = !hit_reg;
        out_item.overflow = overflow_reg;
        out_item.last_slot = last_slot;
        if (hit_reg)
        begin
            out_item.retired_seq = seq_reg[hit_idx_reg];
            out_item.retired_opcode = {1'b0, opc_reg[hit_idx_reg]};
            out_item.retired_pc = pc_reg[hit_idx_reg];
        end
        else
        begin
            out_item.retired_seq = expected_reg;
            out_item.retired_opcode = BUBBLE_OPCODE;
            out_item.retired_pc = '0;
        end
    end

    assign status.hit = hit_reg;

    a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |=> overflow_reg) else $error("overflow flag cleared");
    a_expected_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_retire && !hit_reg) |=> $stable(expected_reg))
        else $error("bubble advanced the counter");
    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_retire && hit_reg) |-> (valid_reg[hit_idx_reg] && fin_reg[hit_idx_reg]))
        else $error("retiring an entry that is not finished");

endmodule

// ===== hdl/latency_countdown_in_order_retire.sv =====
`timescale 1ns / 1ps

// Instruction window with latency countdown and in-order retire.
// The input channel (in_valid, in_stall, in_item) carries two kinds of item.
// An accept item stores one instruction in the lowest free entry; it
// produces no output. When the window is full the instruction
// is dropped and the sticky overflow flag is set until reset.
// A tick item counts down every pending entry in its accept cycle and then
// produces RETIRE_WIDTH output items, one per slot. Each slot runs a
// search over the window (search state) followed by an output state
// that waits until the receiver takes the item.
// The output channel (out_valid, out_stall, out_item) holds each item stable
// while out_stall is high; the block accepts no new input until the last
// slot of a tick has been taken.
// Reset empties the window, sets the expected sequence number to one and
// clears the overflow flag.
module latency_countdown_in_order_retire #(
    parameter int WINDOW_DEPTH = 32,
    parameter int RETIRE_WIDTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lcir_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lcir_pkg::out_item_t  out_item
);
    import lcir_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       busy;
    logic       last_slot;
    logic       in_fire;
    logic       out_fire;

    assign in_stall = busy;
    assign in_fire = in_valid && !busy;
    assign out_fire = out_valid && !out_stall;

    lcir_ctrl #(
        .RETIRE_WIDTH(RETIRE_WIDTH)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_fire(in_fire),
        .in_action(in_item.action),
        .out_fire(out_fire),
        .busy(busy),
        .out_valid(out_valid),
        .last_slot(last_slot),
        .cmd(cmd)
    );

    lcir_dp #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .in_item(in_item),
        .cmd(cmd),
        .last_slot(last_slot),
        .status(status),
        .out_item(out_item)
    );

    a_bubble_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.is_bubble == !status.hit)) else $error("bubble mismatch");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lcir_pkg::*;

    localparam int DEPTH = 32;
    localparam int SLOTS = 4;
    localparam int STALL_LIMIT = 20000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    latency_countdown_in_order_retire u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item)
    );

    in_item_t  pending_items[$];
    out_item_t expected_slots[$];

    logic                  win_valid[DEPTH];
    logic                  win_done[DEPTH];
    logic [SEQ_W-1:0]      win_seq[DEPTH];
    logic [OPC_W-1:0]      win_opc[DEPTH];
    logic [PC_W-1:0]       win_pc[DEPTH];
    logic [LAT_W-1:0]      win_left[DEPTH];
    logic [SEQ_W-1:0]      next_seq;
    logic                  dropped_seen;

    int  errors;
    int  idle_cycles;
    int  cycle_no;
    bit  stim_done;

    function automatic bit quiet_phase();
        return cycle_no >= 400 && cycle_no < 900;
    endfunction

    task automatic retire_predict(input in_item_t it);
        int        hit;
        int        k;
        out_item_t o;
        if (it.action == ACT_ACCEPT)
        begin
            for (k = 0; k < DEPTH; k++)
            begin
                if (!win_valid[k])
                begin
                    win_valid[k] = 1'b1;
                    win_done[k] = 1'b0;
                    win_seq[k] = it.seq_num;
                    win_opc[k] = it.opcode;
                    win_pc[k] = it.pc;
                    win_left[k] = it.exec_latency;
                    return;
                end
            end
            dropped_seen = 1'b1;
            return;
        end
        for (k = 0; k < DEPTH; k++)
        begin
            if (win_valid[k] && !win_done[k])
            begin
                if (win_left[k] <= 1)
                begin
                    win_left[k] = '0;
                    win_done[k] = 1'b1;
                end
                else
                begin
                    win_left[k] = win_left[k] - 1'b1;
                end
            end
        end
        for (int s = 0; s < SLOTS; s++)
        begin
            hit = -1;
            for (k = 0; k < DEPTH; k++)
            begin
                if (hit < 0 && win_valid[k] && win_done[k] && win_seq[k] == next_seq)
                begin
                    hit = k;
                end
            end
            if (hit >= 0)
            begin
                o.is_bubble = 1'b0;
                o.retired_seq = win_seq[hit];
                o.retired_opcode = {1'b0, win_opc[hit]};
                o.retired_pc = win_pc[hit];
                win_valid[hit] = 1'b0;
                win_done[hit] = 1'b0;
                next_seq = next_seq + 1'b1;
            end
            else
            begin
                o.is_bubble = 1'b1;
                o.retired_seq = next_seq;
                o.retired_opcode = BUBBLE_OPCODE;
                o.retired_pc = '0;
            end
            o.overflow = dropped_seen;
            o.last_slot = (s == SLOTS - 1);
            expected_slots = {expected_slots, o};
        end
    endtask

    function automatic in_item_t make_insn(input logic [SEQ_W-1:0] sq,
                                           input logic [LAT_W-1:0] lat);
        in_item_t it;
        it.action = ACT_ACCEPT;
        it.seq_num = sq;
        it.opcode = OPC_W'($urandom);
        it.pc = {$urandom, $urandom};
        it.exec_latency = lat;
        return it;
    endfunction

    function automatic in_item_t make_tick();
        in_item_t    it;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        it.action = ACT_TICK;
        return it;
    endfunction

    task automatic add_item(input in_item_t it);
        pending_items = {pending_items, it};
    endtask

    function automatic void k_init();
        for (int k = 0; k < DEPTH; k++)
        begin
            win_valid[k] = 1'b0;
            win_done[k] = 1'b0;
        end
        next_seq = 32'd1;
        dropped_seen = 1'b0;
        errors = 0;
        idle_cycles = 0;
        cycle_no = 0;
        stim_done = 1'b0;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        logic [SEQ_W-1:0] sq;
        in_item_t it;
        int n;
        int lat;
        k_init();
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        in_item = '0;
        it = make_insn(32'd1, 8'd0);
        it.opcode = '1;
        it.pc = '1;
        add_item(it);
        it = make_insn(32'd2, 8'd1);
        it.opcode = '0;
        it.pc = '0;
        add_item(it);
        add_item(make_insn(32'd4, 8'd2));
        add_item(make_insn(32'd3, 8'd255));
        add_item(make_insn(32'd3, 8'd1));
        add_item(make_insn(32'hFFFF_FFFF, 8'd1));
        add_item(make_tick());
        add_item(make_tick());
        add_item(make_tick());
        for (int i = 0; i < 34; i++)
        begin
            add_item(make_insn(32'd5 + i, 8'd3));
        end
        add_item(make_tick());
        sq = 32'd35;
        n = 0;
        while (n < 276)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                int cnt;
                cnt = $urandom_range(1, 6);
                for (int j = 0; j < cnt; j++)
                begin
                    lat = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 4);
                    add_item(make_insn(sq + $urandom_range(0, cnt - 1), LAT_W'(lat)));
                    n++;
                end
                sq = sq + cnt;
            end
            else
            begin
                add_item(make_insn($urandom, LAT_W'($urandom)));
                n++;
            end
            for (int j = $urandom_range(1, 3); j > 0; j--)
            begin
                add_item(make_tick());
                n++;
            end
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_no <= cycle_no + 1;
            if (in_valid && !in_stall)
            begin
                retire_predict(in_item);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() > 0 &&
                    (quiet_phase() || $urandom_range(0, 99) >= 12))
                begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (pending_items.size() == 0)
                    begin
                        stim_done <= 1'b1;
                    end
                end
            end
            out_stall <= !quiet_phase() && $urandom_range(0, 99) < 12;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_slots.size() == 0)
                begin
                    $display("%0t unexpected item: expected none, actual %h", $time, out_item);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_slots.pop_front();
                    if (want !== out_item)
                    begin
                        $display("%0t mismatch: expected %h, actual %h", $time, want, out_item);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    initial
    begin
        wait (rst_n);
        while (!(stim_done && !in_valid && expected_slots.size() == 0) &&
               idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
        end
        else
        begin
            repeat (40) @(posedge clk);
            if (errors == 0 && expected_slots.size() == 0)
            begin
                $display("end of test: clean");
            end
            else
            begin
                $display("end of test: mismatches");
            end
        end
        $finish;
    end

endmodule
